@@ sv/rwhp_pkg.sv @@
// Package for the RIFF/WAVE header parser: status codes, tags, length limits
// and the expected PCM format block.
// No dependencies; every other file of the parser uses it.
`default_nettype none

package rwhp_pkg;

	// Field widths.
	localparam int LENGTH_BITS = 32;
	localparam int STATUS_W    = 3;
	localparam int OFFSET_W    = LENGTH_BITS + 1;

	typedef logic [LENGTH_BITS-1:0] len_t;
	typedef logic [STATUS_W-1:0]    status_t;
	typedef logic [OFFSET_W-1:0]    offset_t;

	// Result status codes.
	localparam status_t ST_FOUND     = 3'd0;
	localparam status_t ST_BAD_RIFF  = 3'd1;
	localparam status_t ST_RIFF_SHORT = 3'd2;
	localparam status_t ST_BAD_WAVE  = 3'd3;
	localparam status_t ST_NO_SPACE  = 3'd4;
	localparam status_t ST_FMT_SMALL = 3'd5;
	localparam status_t ST_WRONG_FMT = 3'd6;
	localparam status_t ST_TRUNCATED = 3'd7;

	// Chunk tags as they appear little-endian in the header word.
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// Length limits.
	localparam len_t MIN_RIFF_LEN = len_t'(4 + 8 + 16 + 8 + 1);
	localparam len_t FMT_MIN      = len_t'(16);
	localparam len_t CHUNK_HDR    = len_t'(8);
	localparam len_t WAVE_TAG_LEN = len_t'(4);

	// Expected fmt body: PCM, two channels, 44100 Hz, 16 bits per sample.
	function automatic logic [7:0] pcm_format_byte(input logic [3:0] idx);
		logic [7:0] val;
		case (idx)
			4'd0:    val = 8'h01;
			4'd2:    val = 8'h02;
			4'd4:    val = 8'h44;
			4'd5:    val = 8'hac;
			4'd8:    val = 8'h10;
			4'd9:    val = 8'hb1;
			4'd10:   val = 8'h02;
			4'd12:   val = 8'h04;
			4'd14:   val = 8'h10;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

@@ sv/rwhp_byte_if.sv @@
// Valid/ready channel interfaces of the RIFF/WAVE header parser: the file
// byte stream and the result stream.
// Depends on rwhp_pkg for the result field widths.
`default_nettype none

interface rwhp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       start_of_file;
	logic       end_of_file;

	modport source(output valid, file_byte, start_of_file, end_of_file, input ready);
	modport sink(input valid, file_byte, start_of_file, end_of_file, output ready);
endinterface

interface rwhp_result_if;
	logic                                valid;
	logic                                ready;
	logic [rwhp_pkg::STATUS_W-1:0]       status;
	logic [rwhp_pkg::OFFSET_W-1:0]       data_offset;
	logic [rwhp_pkg::LENGTH_BITS-1:0]    data_length;

	modport source(output valid, status, data_offset, data_length, input ready);
	modport sink(input valid, status, data_offset, data_length, output ready);
endinterface

`default_nettype wire

@@ sv/riff_wave_header_parser_core.sv @@
// Top level of the RIFF/WAVE header parser: byte-serial header walk with a
// two-entry result buffer. Depends on rwhp_pkg and the interfaces in rwhp_byte_if.sv.
`default_nettype none

// The parser takes one file byte per cycle and answers each file with at most
// one item on the result channel: status 0 with the data payload offset and
// length, or an error code. Each byte is judged in the cycle it is accepted
// by the parse state machine, and the result that it decides is registered.
// Results go into an output register backed by one skid register, so
// stream.ready falls only while both hold a result that has not been taken;
// otherwise a byte is accepted every cycle. Bytes that arrive before the first
// start_of_file or after a verdict are consumed and ignored.
module riff_wave_header_parser_core (
	input  wire            clk,
	input  wire            arst_n,
	rwhp_byte_if.sink      stream,
	rwhp_result_if.source  result
);
	import rwhp_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_RIFF, PH_WAVE, PH_FMT_HDR, PH_FMT_SKIP,
		PH_FMT_BODY, PH_FMT_TAIL, PH_DATA_HDR, PH_DATA_SKIP, PH_DONE
	} phase_t;

	typedef struct packed {
		status_t status;
		offset_t data_offset;
		len_t    data_length;
	} result_t;

	localparam offset_t PAYLOAD_GAP = offset_t'(2 * CHUNK_HDR);

	// Parse state.
	phase_t      phase_q;
	logic [3:0]  fbc_q;
	logic [63:0] hs_q;
	len_t        total_q;
	len_t        rr_q;
	len_t        cl_q;
	len_t        skip_q;
	logic        fmt_ok_q;

	// Result buffer.
	result_t out_q, skid_q;
	logic    out_vld_q, skid_vld_q;

	// Next-state and result signals.
	phase_t      n_phase;
	logic [3:0]  n_fbc;
	logic [63:0] n_hs;
	len_t        n_total, n_rr, n_cl, n_skip;
	logic        n_fmt_ok;
	logic        emit;
	result_t     res;

	// Working values.
	phase_t      cur_phase;
	logic [3:0]  cur_fbc;
	logic [63:0] cur_hs, hs_new;
	len_t        cur_total, cur_rr, cur_cl, cur_skip;
	logic        cur_fmt_ok;
	logic        hdr_done;
	len_t        tag, sub, rr_hdr, rr_after, skip_dec;
	logic        search_go, fmt_finish, finish_ok;
	len_t        search_rem;
	phase_t      search_next;
	logic        accept, pop;

	assign accept       = stream.valid && stream.ready;
	assign pop          = result.valid && result.ready;
	assign stream.ready = !skid_vld_q;

	// Byte-level parse logic.
	always_comb begin
		// A start mark restarts the walk from a clean state.
		if (stream.start_of_file) begin
			cur_phase  = PH_RIFF;
			cur_fbc    = '0;
			cur_hs     = '0;
			cur_total  = '0;
			cur_rr     = '0;
			cur_cl     = '0;
			cur_skip   = '0;
			cur_fmt_ok = 1'b1;
		end else begin
			cur_phase  = phase_q;
			cur_fbc    = fbc_q;
			cur_hs     = hs_q;
			cur_total  = total_q;
			cur_rr     = rr_q;
			cur_cl     = cl_q;
			cur_skip   = skip_q;
			cur_fmt_ok = fmt_ok_q;
		end

		hs_new = cur_hs;
		hs_new[cur_fbc[2:0]*8 +: 8] = stream.file_byte;
		tag      = hs_new[31:0];
		sub      = hs_new[63:32];
		rr_hdr   = cur_rr - CHUNK_HDR;
		rr_after = rr_hdr - sub;
		skip_dec = cur_skip - len_t'(1);
		hdr_done = (cur_phase == PH_WAVE) ? (cur_fbc[1:0] == 2'd3) : (cur_fbc[2:0] == 3'd7);

		n_phase  = phase_q;
		n_fbc    = fbc_q;
		n_hs     = hs_q;
		n_total  = total_q;
		n_rr     = rr_q;
		n_cl     = cl_q;
		n_skip   = skip_q;
		n_fmt_ok = fmt_ok_q;
		emit     = 1'b0;
		res      = '{status: ST_FOUND, data_offset: '0, data_length: '0};

		search_go   = 1'b0;
		search_rem  = cur_rr;
		search_next = PH_FMT_HDR;
		fmt_finish  = 1'b0;
		finish_ok   = cur_fmt_ok;

		if (accept) begin
			n_phase  = cur_phase;
			n_fbc    = cur_fbc;
			n_hs     = cur_hs;
			n_total  = cur_total;
			n_rr     = cur_rr;
			n_cl     = cur_cl;
			n_skip   = cur_skip;
			n_fmt_ok = cur_fmt_ok;

			if (cur_phase != PH_IDLE && cur_phase != PH_DONE) begin
				if (stream.end_of_file) begin
					emit       = 1'b1;
					res.status = ST_TRUNCATED;
				end else begin
					case (cur_phase)
						PH_RIFF, PH_WAVE, PH_FMT_HDR, PH_DATA_HDR: begin
							n_hs  = hs_new;
							n_fbc = cur_fbc + 4'd1;
							if (hdr_done) begin
								case (cur_phase)
									PH_RIFF: begin
										if (tag != TAG_RIFF) begin
											emit       = 1'b1;
											res.status = ST_BAD_RIFF;
										end else if (sub < MIN_RIFF_LEN) begin
											emit       = 1'b1;
											res.status = ST_RIFF_SHORT;
										end else begin
											n_total = sub;
											n_rr    = sub;
											n_phase = PH_WAVE;
											n_fbc   = '0;
											n_hs    = '0;
										end
									end
									PH_WAVE: begin
										n_rr = cur_rr - WAVE_TAG_LEN;
										if (tag != TAG_WAVE) begin
											emit       = 1'b1;
											res.status = ST_BAD_WAVE;
										end else begin
											search_go   = 1'b1;
											search_rem  = cur_rr - WAVE_TAG_LEN;
											search_next = PH_FMT_HDR;
										end
									end
									default: begin
										// Chunk header: length check comes before the tag.
										n_cl = sub;
										n_rr = rr_hdr;
										if (rr_hdr < sub) begin
											emit       = 1'b1;
											res.status = ST_NO_SPACE;
										end else if (cur_phase == PH_DATA_HDR && tag == TAG_DATA) begin
											emit            = 1'b1;
											res.status      = ST_FOUND;
											res.data_offset = {1'b0, cur_total} - {1'b0, cur_rr}
												+ PAYLOAD_GAP;
											res.data_length = sub;
										end else if (cur_phase == PH_FMT_HDR && tag == TAG_FMT) begin
											if (sub < FMT_MIN) begin
												emit       = 1'b1;
												res.status = ST_FMT_SMALL;
											end else begin
												n_rr     = rr_after;
												n_fmt_ok = 1'b1;
												n_fbc    = '0;
												n_phase  = PH_FMT_BODY;
											end
										end else begin
											n_rr = rr_after;
											if (sub == '0) begin
												search_go   = 1'b1;
												search_rem  = rr_after;
												search_next = cur_phase;
											end else begin
												n_skip  = sub;
												n_phase = (cur_phase == PH_FMT_HDR) ?
													PH_FMT_SKIP : PH_DATA_SKIP;
											end
										end
									end
								endcase
							end
						end
						PH_FMT_SKIP, PH_DATA_SKIP: begin
							n_skip = skip_dec;
							if (skip_dec == '0) begin
								search_go   = 1'b1;
								search_rem  = cur_rr;
								search_next = (cur_phase == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
							end
						end
						PH_FMT_BODY: begin
							finish_ok = cur_fmt_ok &&
								(stream.file_byte == pcm_format_byte(cur_fbc));
							n_fmt_ok = finish_ok;
							if (cur_fbc != 4'd15) begin
								n_fbc = cur_fbc + 4'd1;
							end else begin
								n_fbc = '0;
								if (cur_cl > FMT_MIN) begin
									n_skip  = cur_cl - FMT_MIN;
									n_phase = PH_FMT_TAIL;
								end else begin
									fmt_finish = 1'b1;
								end
							end
						end
						PH_FMT_TAIL: begin
							n_skip = skip_dec;
							if (skip_dec == '0) begin
								fmt_finish = 1'b1;
							end
						end
						default: begin
							n_phase = PH_DONE;
						end
					endcase

					// Format verdict after the whole fmt chunk has gone by.
					if (fmt_finish) begin
						if (!finish_ok) begin
							emit       = 1'b1;
							res.status = ST_WRONG_FMT;
						end else begin
							search_go   = 1'b1;
							search_rem  = cur_rr;
							search_next = PH_DATA_HDR;
						end
					end

					// Entering a chunk search needs room for a chunk header.
					if (search_go) begin
						if (search_rem < CHUNK_HDR) begin
							emit       = 1'b1;
							res.status = ST_NO_SPACE;
						end else begin
							n_phase = search_next;
							n_fbc   = '0;
							n_hs    = '0;
						end
					end
				end
				if (emit) begin
					n_phase = PH_DONE;
				end
			end
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			fbc_q    <= '0;
			hs_q     <= '0;
			total_q  <= '0;
			rr_q     <= '0;
			cl_q     <= '0;
			skip_q   <= '0;
			fmt_ok_q <= 1'b1;
		end else begin
			phase_q  <= n_phase;
			fbc_q    <= n_fbc;
			hs_q     <= n_hs;
			total_q  <= n_total;
			rr_q     <= n_rr;
			cl_q     <= n_cl;
			skip_q   <= n_skip;
			fmt_ok_q <= n_fmt_ok;
		end
	end

	// Result register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_vld_q) begin
				if (pop) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= 1'b0;
				end
			end else if (emit) begin
				if (out_vld_q && !pop) begin
					skid_vld_q <= 1'b1;
				end else begin
					out_vld_q <= 1'b1;
				end
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (emit) begin
			if (out_vld_q && !pop) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign result.valid       = out_vld_q;
	assign result.status      = out_q.status;
	assign result.data_offset = out_q.data_offset;
	assign result.data_length = out_q.data_length;

endmodule

`default_nettype wire

@@ sv/rwhp_checker.sv @@
// Port-level checks for the RIFF/WAVE header parser, attached to the top
// level by a bind statement. Depends on rwhp_pkg for status codes and widths.
`default_nettype none

module rwhp_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               in_valid,
	input wire                               in_ready,
	input wire                               out_valid,
	input wire                               out_ready,
	input wire [rwhp_pkg::STATUS_W-1:0]      status,
	input wire [rwhp_pkg::OFFSET_W-1:0]      data_offset,
	input wire [rwhp_pkg::LENGTH_BITS-1:0]   data_length
);
	import rwhp_pkg::*;

	localparam offset_t MIN_PAYLOAD_OFFSET = offset_t'(44);

	// A result that is not taken stays on the port unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(data_offset) && $stable(data_length))
		else $error("result changed while stalled");

	// The byte side stalls only while a result is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// A new result follows an accepted item.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result appeared without an accepted item");

	// Error results carry no offset or length.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_FOUND |-> data_offset == '0 && data_length == '0)
		else $error("error result with nonzero offset or length");

	// The payload cannot start before the smallest legal header ends.
	a_found_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FOUND |-> data_offset >= MIN_PAYLOAD_OFFSET)
		else $error("data offset inside the minimum header");

endmodule

bind riff_wave_header_parser_core rwhp_checker u_rwhp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (stream.valid),
	.in_ready    (stream.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.status      (result.status),
	.data_offset (result.data_offset),
	.data_length (result.data_length)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for riff_wave_header_parser_core: streams RIFF/WAVE files one byte
// per item and checks every verdict against an in-bench header walker.
// Depends on rwhp_pkg, the rwhp_byte_if/rwhp_result_if interfaces and the parser RTL.
`default_nettype none

module tb_top;
	import rwhp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LIVE_PER_PHASE = 140;
	localparam int VERDICTS_PER_PHASE = 3;
	localparam int HOLD_CYCLES = 400;
	localparam int FILL_FILES = 12;
	localparam int TAIL_CYCLES = 4;

	// Expected fmt body for 16-bit stereo 44100 Hz PCM.
	localparam logic [7:0] PCM_BODY [16] = '{
		8'h01, 8'h00, 8'h02, 8'h00, 8'h44, 8'hac, 8'h00, 8'h00,
		8'h10, 8'hb1, 8'h02, 8'h00, 8'h04, 8'h00, 8'h10, 8'h00
	};

	typedef enum logic [3:0] {
		W_IDLE, W_RIFF, W_WAVE, W_FMT_HDR, W_FMT_SKIP, W_FMT_BODY,
		W_FMT_TAIL, W_DATA_HDR, W_DATA_SKIP, W_DONE
	} walk_phase_t;

	typedef struct packed {
		status_t status;
		offset_t data_offset;
		len_t    data_length;
	} verdict_t;

	// Header walker that predicts the verdict of each file and checks the results.
	class wave_verdict_board;
		walk_phase_t phase;
		logic [3:0]  field_count;
		logic [63:0] hdr_bits;
		len_t        riff_len;
		len_t        space_left;
		len_t        chunk_len;
		len_t        skip_left;
		logic        fmt_ok;
		verdict_t    awaited[$];
		int          error_count;
		int          verdict_count;
		int          predicted_count;
		int          live_bytes;
		logic [7:0]  status_seen;

		function new();
			clear_walk();
			phase = W_IDLE;
			error_count = 0;
			verdict_count = 0;
			predicted_count = 0;
			live_bytes = 0;
			status_seen = '0;
		endfunction

		function void clear_walk();
			phase = W_IDLE;
			field_count = '0;
			hdr_bits = '0;
			riff_len = '0;
			space_left = '0;
			chunk_len = '0;
			skip_left = '0;
			fmt_ok = 1'b1;
		endfunction

		function void record_verdict(status_t st, offset_t off, len_t len);
			verdict_t v;
			v.status = st;
			v.data_offset = off;
			v.data_length = len;
			awaited.push_back(v);
			predicted_count++;
			phase = W_DONE;
		endfunction

		// A chunk header needs at least eight bytes of RIFF space.
		function void seek_chunk(walk_phase_t next);
			if (space_left < CHUNK_HDR) begin
				record_verdict(ST_NO_SPACE, '0, '0);
				return;
			end
			phase = next;
			field_count = '0;
			hdr_bits = '0;
		endfunction

		function void close_fmt();
			if (!fmt_ok) begin
				record_verdict(ST_WRONG_FMT, '0, '0);
				return;
			end
			seek_chunk(W_DATA_HDR);
		endfunction

		// The length is checked against the space left before the tag is compared.
		function void judge_chunk(logic [31:0] want, walk_phase_t skip_ph, walk_phase_t hdr_ph);
			logic [31:0] tag;
			len_t        sub;
			tag = hdr_bits[31:0];
			sub = hdr_bits[63:32];
			space_left = space_left - CHUNK_HDR;
			chunk_len = sub;
			if (space_left < sub) begin
				record_verdict(ST_NO_SPACE, '0, '0);
				return;
			end
			if (tag == want) begin
				if (want == TAG_DATA) begin
					record_verdict(ST_FOUND, offset_t'(riff_len) - offset_t'(space_left)
						+ offset_t'(CHUNK_HDR), sub);
					return;
				end
				if (sub < FMT_MIN) begin
					record_verdict(ST_FMT_SMALL, '0, '0);
					return;
				end
				space_left = space_left - sub;
				fmt_ok = 1'b1;
				field_count = '0;
				phase = W_FMT_BODY;
				return;
			end
			space_left = space_left - sub;
			if (sub == '0)
				seek_chunk(hdr_ph);
			else begin
				skip_left = sub;
				phase = skip_ph;
			end
		endfunction

		// Advances the walk by one accepted item.
		function void note_byte(logic [7:0] b, logic sof, logic eof);
			int need;
			if (sof) begin
				clear_walk();
				phase = W_RIFF;
			end
			if (phase == W_IDLE || phase == W_DONE)
				return;
			live_bytes++;
			if (eof) begin
				record_verdict(ST_TRUNCATED, '0, '0);
				return;
			end
			case (phase)
				W_RIFF, W_WAVE, W_FMT_HDR, W_DATA_HDR: begin
					need = (phase == W_WAVE) ? 4 : 8;
					hdr_bits = hdr_bits | (64'(b) << (8 * field_count[2:0]));
					field_count = field_count + 4'd1;
					if (field_count < need)
						return;
					if (phase == W_RIFF) begin
						if (hdr_bits[31:0] != TAG_RIFF) begin
							record_verdict(ST_BAD_RIFF, '0, '0);
							return;
						end
						riff_len = hdr_bits[63:32];
						if (riff_len < MIN_RIFF_LEN) begin
							record_verdict(ST_RIFF_SHORT, '0, '0);
							return;
						end
						space_left = riff_len;
						phase = W_WAVE;
						field_count = '0;
						hdr_bits = '0;
					end else if (phase == W_WAVE) begin
						space_left = space_left - WAVE_TAG_LEN;
						if (hdr_bits[31:0] != TAG_WAVE)
							record_verdict(ST_BAD_WAVE, '0, '0);
						else
							seek_chunk(W_FMT_HDR);
					end else if (phase == W_FMT_HDR)
						judge_chunk(TAG_FMT, W_FMT_SKIP, W_FMT_HDR);
					else
						judge_chunk(TAG_DATA, W_DATA_SKIP, W_DATA_HDR);
				end
				W_FMT_SKIP, W_DATA_SKIP: begin
					skip_left = skip_left - 1;
					if (skip_left == '0)
						seek_chunk(phase == W_FMT_SKIP ? W_FMT_HDR : W_DATA_HDR);
				end
				W_FMT_BODY: begin
					if (b != PCM_BODY[field_count])
						fmt_ok = 1'b0;
					if (field_count != 4'd15) begin
						field_count = field_count + 4'd1;
						return;
					end
					field_count = '0;
					if (chunk_len > FMT_MIN) begin
						skip_left = chunk_len - FMT_MIN;
						phase = W_FMT_TAIL;
					end else
						close_fmt();
				end
				W_FMT_TAIL: begin
					skip_left = skip_left - 1;
					if (skip_left == '0)
						close_fmt();
				end
				default: phase = W_DONE;
			endcase
		endfunction

		// Compares one accepted result with the oldest predicted verdict.
		function void check_verdict(status_t st, offset_t off, len_t len);
			verdict_t want;
			if (awaited.size() == 0) begin
				$error("unexpected result: status %0d offset %0d length %0d", st, off, len);
				error_count++;
				return;
			end
			want = awaited.pop_front();
			verdict_count++;
			status_seen[st] = 1'b1;
			if (st !== want.status) begin
				$error("status mismatch: expected %0d, actual %0d", want.status, st);
				error_count++;
			end
			if (off !== want.data_offset) begin
				$error("data_offset mismatch: expected %0d, actual %0d", want.data_offset, off);
				error_count++;
			end
			if (len !== want.data_length) begin
				$error("data_length mismatch: expected %0d, actual %0d", want.data_length, len);
				error_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_request;
	int   hold_left = 0;
	int   cycle_count = 0;
	int   files_sent = 0;
	logic [7:0] file_bytes[$];
	wave_verdict_board sb;

	rwhp_byte_if   stream_ch();
	rwhp_result_if result_ch();

	riff_wave_header_parser_core DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.stream(stream_ch),
		.result(result_ch)
	);

	// Clock with a 12 unit period.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Both handshakes are sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				sb.check_verdict(result_ch.status, result_ch.data_offset, result_ch.data_length);
			if (stream_ch.valid && stream_ch.ready)
				sb.note_byte(stream_ch.file_byte, stream_ch.start_of_file,
					stream_ch.end_of_file);
		end
	end

	// Result receiver: random stalls, plus a long hold-off when requested.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Offers one item and returns at the falling edge after it is accepted.
	task automatic send_item(input logic [7:0] b, input logic sof, input logic eof);
		while ($urandom_range(99) < send_idle_pct) begin
			stream_ch.valid <= 1'b0;
			@(negedge clk);
		end
		stream_ch.valid <= 1'b1;
		stream_ch.file_byte <= b;
		stream_ch.start_of_file <= sof;
		stream_ch.end_of_file <= eof;
		do
			@(posedge clk);
		while (!stream_ch.ready);
		@(negedge clk);
	endtask

	// Sends the queued file, marking its first byte as the start.
	task automatic send_file(input logic with_eof);
		foreach (file_bytes[i])
			send_item(file_bytes[i], i == 0, 1'b0);
		if (with_eof)
			send_item(8'($urandom), 1'b0, 1'b1);
		files_sent++;
	endtask

	task automatic push_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			file_bytes.push_back(w[8*i +: 8]);
	endtask

	// Chunk that the search skips; now and then its length overruns the space.
	task automatic add_filler(input logic [31:0] alt_tag);
		int          flen;
		logic [31:0] tag;
		logic [31:0] len_field;
		flen = $urandom_range(0, 6);
		case ($urandom_range(3))
			0:       tag = alt_tag;
			1:       tag = TAG_RIFF;
			default: tag = $urandom;
		endcase
		len_field = ($urandom_range(19) == 0) ? $urandom : flen;
		push_word(tag);
		push_word(len_field);
		repeat (flen) file_bytes.push_back(8'($urandom));
	endtask

	// Builds a mostly well-formed file with random damage and sends it.
	task automatic send_wave_file();
		int              r;
		int              clen;
		int              cut;
		logic            with_eof;
		len_t            data_len;
		longint unsigned riff_sum;
		len_t            riff_field;
		file_bytes.delete();
		push_word(TAG_RIFF);
		push_word('0);
		push_word(TAG_WAVE);
		if ($urandom_range(99) >= 60)
			repeat ($urandom_range(1, 2)) add_filler(TAG_DATA);

		// fmt chunk: exact size, with trailing bytes, or too small.
		r = $urandom_range(99);
		clen = (r < 70) ? 16 : (r < 88) ? 16 + $urandom_range(1, 5) : $urandom_range(0, 15);
		push_word(TAG_FMT);
		push_word(clen);
		if (clen >= 16) begin
			cut = ($urandom_range(3) == 0) ? $urandom_range(0, 15) : -1;
			for (int i = 0; i < 16; i++)
				file_bytes.push_back((i == cut) ? 8'($urandom) : PCM_BODY[i]);
			repeat (clen - 16) file_bytes.push_back(8'($urandom));
		end else
			repeat (clen) file_bytes.push_back(8'($urandom));

		if ($urandom_range(99) >= 60)
			repeat ($urandom_range(1, 2)) add_filler(TAG_FMT);

		// data chunk and the RIFF length that covers it.
		r = $urandom_range(99);
		data_len = (r < 50) ? len_t'($urandom_range(0, 64)) : (r < 85) ? len_t'($urandom)
			: '1;
		push_word(TAG_DATA);
		push_word(data_len);
		riff_sum = longint'(file_bytes.size() - 8) + longint'(data_len);
		riff_field = (riff_sum > 64'hFFFF_FFFF) ? '1 : len_t'(riff_sum);
		r = $urandom_range(99);
		if (r < 12)
			riff_field = riff_field - len_t'($urandom_range(1, 12));
		else if (r < 20)
			riff_field = len_t'($urandom_range(0, 40));
		else if (r < 23)
			riff_field = '1;
		else if (r < 26)
			riff_field = $urandom;
		for (int i = 0; i < 4; i++)
			file_bytes[4 + i] = riff_field[8*i +: 8];
		repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));

		// Occasional single-bit damage anywhere, tags included.
		if ($urandom_range(99) < 8) begin
			cut = $urandom_range(0, file_bytes.size() - 1);
			file_bytes[cut] = file_bytes[cut] ^ (8'h01 << $urandom_range(0, 7));
		end

		// Ending: cut short with or without an end mark, whole with one, or bare.
		r = $urandom_range(99);
		with_eof = (r < 10) || (r >= 18 && r < 55);
		if (r < 18) begin
			cut = $urandom_range(1, file_bytes.size() - 1);
			while (file_bytes.size() > cut)
				void'(file_bytes.pop_back());
		end
		send_file(with_eof);

		// Stray items between files.
		if ($urandom_range(99) < 10)
			repeat ($urandom_range(1, 3))
				send_item(8'($urandom), 1'b0, 1'($urandom));
	endtask

	// Pauses the sender until every predicted verdict has been taken.
	task automatic wait_for_verdicts();
		stream_ch.valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		sb = new();
		hold_request = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		stream_ch.valid = 1'b0;
		stream_ch.file_byte = '0;
		stream_ch.start_of_file = 1'b0;
		stream_ch.end_of_file = 1'b0;
		result_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: stray items before any start, an empty file, a bad tag,
		// a RIFF length one below the minimum, and an end mark mid-length.
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h5A, 1'b0, 1'b1);
		send_item(8'($urandom), 1'b1, 1'b1);
		file_bytes = '{8'h52, 8'h49, 8'h46, 8'h58, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_file(1'b0);
		file_bytes = '{8'h52, 8'h49, 8'h46, 8'h46, 8'h24, 8'h00, 8'h00, 8'h00};
		send_file(1'b0);
		file_bytes = '{8'h52, 8'h49, 8'h46, 8'h46, 8'h01, 8'h02, 8'h03};
		send_file(1'b1);
		wait_for_verdicts();

		// Random files under four idling patterns.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			while (sb.live_bytes < LIVE_PER_PHASE * (p + 1)
					|| sb.predicted_count < VERDICTS_PER_PHASE * (p + 1))
				send_wave_file();
			wait_for_verdicts();

			// Result buffer fill: receiver holds off while empty files keep coming.
			if (p == 1) begin
				send_idle_pct = 0;
				hold_request = 1'b1;
				repeat (FILL_FILES) begin
					send_item(8'($urandom), 1'b1, 1'b1);
					files_sent++;
				end
				wait_for_verdicts();
			end
		end

		if (sb.awaited.size() != 0) begin
			$error("%0d predicted verdicts never arrived", sb.awaited.size());
			sb.error_count++;
		end
		$display("Streamed %0d files (%0d parsed byte items), checked %0d verdicts;",
			files_sent, sb.live_bytes, sb.verdict_count);
		$display("status codes observed (bit per code): %b", sb.status_seen);
		if (sb.error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
